// File: hdl/gbsp_pkg.sv
// Shared types, constants and move tables for the grid path search unit.
package gbsp_pkg;

    localparam int COORD_W    = 7;
    localparam int STEPS_W    = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [STEPS_W-1:0] STEPS_MAX = 12'd4095;

    typedef logic [2:0] t_dir;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_COLS = 3'd0,
        REG_GRID_ROWS = 3'd1,
        REG_START_COL = 3'd2,
        REG_START_ROW = 3'd3,
        REG_GOAL_COL  = 3'd4,
        REG_GOAL_ROW  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic clr_blk_we;
        logic clr_vis_we;
        logic sweep_inc;
        logic sweep_rst;
        logic load_we;
        logic nb_latch;
        logic sel_start;
        t_dir k;
        logic open_store;
        logic q_reset;
        logic seed;
        logic pop;
        logic push;
        logic res_load;
        logic res_found;
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
        logic cfg_ok;
        logic at_goal;
        logic q_empty;
        logic pass;
        logic visited;
        logic out_full;
    } t_sts;

    function automatic logic [COORD_W:0] move_dx(input t_dir k);
        logic [COORD_W:0] d;
        case (k)
            3'd1, 3'd2, 3'd3: d = 8'd1;
            3'd5, 3'd6, 3'd7: d = 8'hFF;
            default:          d = 8'd0;
        endcase
        return d;
    endfunction

    function automatic logic [COORD_W:0] move_dy(input t_dir k);
        logic [COORD_W:0] d;
        case (k)
            3'd0, 3'd1, 3'd7: d = 8'd1;
            3'd3, 3'd4, 3'd5: d = 8'hFF;
            default:          d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/gbsp_if.sv
// Channel interfaces: map cells in, search results out, register writes.
interface gbsp_cell_if;
    logic valid;
    logic ready;
    logic cell_blocked;
    logic last_cell;
    modport source (output valid, output cell_blocked, output last_cell, input ready);
    modport sink   (input valid, input cell_blocked, input last_cell, output ready);
endinterface

interface gbsp_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [11:0] steps;
    modport source (output valid, output found, output steps, input ready);
    modport sink   (input valid, input found, input steps, output ready);
endinterface

interface gbsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] addr;
    logic [6:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: hdl/grid_bfs_shortest_path_unit.sv
// Top level of the 8-connected grid shortest-path search unit.
// Map cells stream in row-major order at one cell per cycle while the unit is loading a
// map; the cell flagged last ends the map and starts the search, which gives one result
// (found, steps). After reset the unit clears the obstacle map before it takes the
// first cell. A search first clears the visited map, then for each dequeued cell
// fetches its eight neighbors from the obstacle map one at a time, and then checks
// each passable neighbor against the visited map, marks it and enqueues it; a search
// that reaches the goal early stops at once. Register writes are taken at any time
// with ready held high.
module grid_bfs_shortest_path_unit #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbsp_cell_if.sink  i_cell,
    gbsp_res_if.source o_res,
    gbsp_cfg_if.sink   i_cfg
);
    import gbsp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    gbsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cell.valid),
        .i_in_last  (i_cell.last_cell),
        .i_sts      (sts),
        .o_in_ready (i_cell.ready),
        .o_cmd      (cmd)
    );

    gbsp_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cell_blocked (i_cell.cell_blocked),
        .i_last_cell    (i_cell.last_cell),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_addr     (i_cfg.addr),
        .i_cfg_data     (i_cfg.data),
        .i_res_ready    (o_res.ready),
        .o_res_valid    (o_res.valid),
        .o_found        (o_res.found),
        .o_steps        (o_res.steps)
    );

endmodule

// File: hdl/gbsp_dp.sv
// Datapath: config registers, map memories, frontier queue, neighbor unit, result register.
module gbsp_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gbsp_pkg::t_cmd                      i_cmd,
    output gbsp_pkg::t_sts                      o_sts,
    input  logic                                i_cell_blocked,
    input  logic                                i_last_cell,
    input  logic                                i_cfg_we,
    input  logic [gbsp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [gbsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_res_ready,
    output logic                                o_res_valid,
    output logic                                o_found,
    output logic [gbsp_pkg::STEPS_W-1:0]        o_steps
);
    import gbsp_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = AW + 1;
    localparam int PW    = 2 * COORD_W;
    localparam int QW    = DW + PW;

    logic [COORD_W-1:0] r_grid_cols, r_grid_rows;
    logic [COORD_W-2:0] r_start_col, r_start_row, r_goal_col, r_goal_row;
    logic [COORD_W-1:0] eff_cols, eff_rows;

    logic              r_blk_mem [CELLS];
    logic              r_vis_mem [CELLS];
    logic [QW-1:0]     r_q_mem   [CELLS];
    logic              r_blk_q, r_vis_q;
    logic [QW-1:0]     r_q_rd;
    logic [DW-1:0]     r_head, r_tail;
    logic [AW:0]       r_load_idx;
    logic [AW-1:0]     r_sweep;
    logic              load_wr;

    logic [COORD_W-1:0] cur_col, cur_row, base_c, base_r;
    logic [DW-1:0]      cur_dist;
    logic [COORD_W:0]   off_c, off_r, nc, nr;
    logic [PW-1:0]      lin;
    logic [PW+AW-1:0]   lin_ext;
    logic [AW-1:0]      r_nb_addr;
    logic               r_nb_inb;
    logic [COORD_W-1:0] r_nb_c, r_nb_r;
    logic [7:0]         r_open;
    t_dir               km, kp;

    logic                  r_res_valid, r_found;
    logic [STEPS_W-1:0]    r_steps;
    logic [DW+STEPS_W-1:0] dist_ext;
    logic [STEPS_W-1:0]    sat_steps;

    always_comb begin
        eff_cols = (int'(r_grid_cols) > MAX_COLS) ? COORD_W'(MAX_COLS) : r_grid_cols;
        eff_rows = (int'(r_grid_rows) > MAX_ROWS) ? COORD_W'(MAX_ROWS) : r_grid_rows;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 7'd64;
            r_grid_rows <= 7'd64;
            r_start_col <= '0;
            r_start_row <= '0;
            r_goal_col  <= '0;
            r_goal_row  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_GRID_COLS: r_grid_cols <= i_cfg_data;
                REG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                REG_START_COL: r_start_col <= i_cfg_data[COORD_W-2:0];
                REG_START_ROW: r_start_row <= i_cfg_data[COORD_W-2:0];
                REG_GOAL_COL:  r_goal_col  <= i_cfg_data[COORD_W-2:0];
                REG_GOAL_ROW:  r_goal_row  <= i_cfg_data[COORD_W-2:0];
                default: ;
            endcase
        end
    end

    assign cur_dist = r_q_rd[QW-1:PW];
    assign cur_col  = r_q_rd[PW-1:COORD_W];
    assign cur_row  = r_q_rd[COORD_W-1:0];

    always_comb begin
        base_c  = i_cmd.sel_start ? {1'b0, r_start_col} : cur_col;
        base_r  = i_cmd.sel_start ? {1'b0, r_start_row} : cur_row;
        off_c   = i_cmd.sel_start ? '0 : move_dx(i_cmd.k);
        off_r   = i_cmd.sel_start ? '0 : move_dy(i_cmd.k);
        nc      = {1'b0, base_c} + off_c;
        nr      = {1'b0, base_r} + off_r;
        lin     = nr[COORD_W-1:0] * eff_cols + {{COORD_W{1'b0}}, nc[COORD_W-1:0]};
        lin_ext = {{AW{1'b0}}, lin};
        km      = i_cmd.k - 3'd1;
        kp      = i_cmd.k + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_latch) begin
            r_nb_addr <= lin_ext[AW-1:0];
            r_nb_inb  <= (nc < {1'b0, eff_cols}) && (nr < {1'b0, eff_rows});
            r_nb_c    <= nc[COORD_W-1:0];
            r_nb_r    <= nr[COORD_W-1:0];
        end
        if (i_cmd.open_store) begin
            r_open[i_cmd.k] <= r_nb_inb & ~r_blk_q;
        end
    end

    assign load_wr = i_cmd.load_we && (r_load_idx < (AW+1)'(CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_sweep    <= '0;
        end else begin
            if (i_cmd.load_we) begin
                if (i_last_cell) begin
                    r_load_idx <= '0;
                end else if (load_wr) begin
                    r_load_idx <= r_load_idx + 1'b1;
                end
            end
            if (i_cmd.sweep_rst) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_inc) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_blk_we) begin
            r_blk_mem[r_sweep] <= 1'b0;
        end else if (load_wr) begin
            r_blk_mem[r_load_idx[AW-1:0]] <= i_cell_blocked;
        end
        r_blk_q <= r_blk_mem[r_nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_vis_we) begin
            r_vis_mem[r_sweep] <= 1'b0;
        end else if (i_cmd.seed || i_cmd.push) begin
            r_vis_mem[r_nb_addr] <= 1'b1;
        end
        r_vis_q <= r_vis_mem[r_nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed) begin
            r_q_mem[r_tail[AW-1:0]] <= {{DW{1'b0}}, r_nb_c, r_nb_r};
        end else if (i_cmd.push) begin
            r_q_mem[r_tail[AW-1:0]] <= {cur_dist + 1'b1, r_nb_c, r_nb_r};
        end
        if (i_cmd.pop) begin
            r_q_rd <= r_q_mem[r_head[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.q_reset) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_cmd.seed || i_cmd.push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_cmd.pop) begin
                r_head <= r_head + 1'b1;
            end
        end
    end

    always_comb begin
        dist_ext  = {{STEPS_W{1'b0}}, cur_dist};
        sat_steps = (dist_ext > (DW+STEPS_W)'(STEPS_MAX)) ? STEPS_MAX
                                                          : dist_ext[STEPS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
        if (i_cmd.res_load) begin
            r_found <= i_cmd.res_found;
            r_steps <= i_cmd.res_found ? sat_steps : '0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_found     = r_found;
    assign o_steps     = r_steps;

    always_comb begin
        o_sts.sweep_done = (r_sweep == AW'(CELLS - 1));
        o_sts.cfg_ok     = (eff_cols != '0) && (eff_rows != '0) &&
                           ({1'b0, r_start_col} < eff_cols) &&
                           ({1'b0, r_start_row} < eff_rows) &&
                           ({1'b0, r_goal_col} < eff_cols) &&
                           ({1'b0, r_goal_row} < eff_rows);
        o_sts.at_goal    = (cur_col == {1'b0, r_goal_col}) && (cur_row == {1'b0, r_goal_row});
        o_sts.q_empty    = (r_head == r_tail);
        o_sts.pass       = r_open[i_cmd.k] && (!i_cmd.k[0] || (r_open[km] && r_open[kp]));
        o_sts.visited    = r_vis_q;
        o_sts.out_full   = r_res_valid;
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_head != r_tail))
        else $error("pop from empty frontier queue");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> !r_res_valid)
        else $error("result overwritten before taken");
    a_push_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.seed || i_cmd.push) |-> r_nb_inb)
        else $error("queued cell outside grid");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.seed || i_cmd.push) |=> (r_tail <= DW'(CELLS)))
        else $error("frontier queue overflow");
`endif

endmodule

// File: hdl/gbsp_ctrl.sv
// Controller: sequences map load, clearing sweeps and the breadth-first search.
module gbsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  gbsp_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output gbsp_pkg::t_cmd o_cmd
);
    import gbsp_pkg::*;

    typedef enum logic [3:0] {
        S_CLRB, S_LOAD, S_CHECK, S_CLRV, S_SEEDA, S_SEEDW, S_POP, S_POPW,
        S_BA, S_BR, S_BS, S_EA, S_ER, S_EC, S_RES
    } t_state;

    t_state r_state;
    t_dir   r_k;
    logic   r_found;

    always_comb begin
        o_cmd           = '0;
        o_cmd.k         = r_k;
        o_cmd.res_found = r_found;
        case (r_state)
            S_CLRB: begin
                o_cmd.clr_blk_we = 1'b1;
                o_cmd.sweep_inc  = 1'b1;
            end
            S_LOAD:  o_cmd.load_we = i_in_valid;
            S_CHECK: o_cmd.sweep_rst = 1'b1;
            S_CLRV: begin
                o_cmd.clr_vis_we = 1'b1;
                o_cmd.sweep_inc  = 1'b1;
            end
            S_SEEDA: begin
                o_cmd.nb_latch  = 1'b1;
                o_cmd.sel_start = 1'b1;
                o_cmd.q_reset   = 1'b1;
            end
            S_SEEDW: o_cmd.seed = 1'b1;
            S_POP:   o_cmd.pop = !i_sts.q_empty;
            S_BA:    o_cmd.nb_latch = 1'b1;
            S_BS:    o_cmd.open_store = 1'b1;
            S_EA:    o_cmd.nb_latch = 1'b1;
            S_EC:    o_cmd.push = !i_sts.visited;
            S_RES:   o_cmd.res_load = !i_sts.out_full;
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLRB;
            r_k     <= '0;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                S_CLRB: if (i_sts.sweep_done) r_state <= S_LOAD;
                S_LOAD: if (i_in_valid && i_in_last) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_sts.cfg_ok) begin
                        r_state <= S_CLRV;
                    end else begin
                        r_found <= 1'b0;
                        r_state <= S_RES;
                    end
                end
                S_CLRV:  if (i_sts.sweep_done) r_state <= S_SEEDA;
                S_SEEDA: r_state <= S_SEEDW;
                S_SEEDW: r_state <= S_POP;
                S_POP: begin
                    if (i_sts.q_empty) begin
                        r_found <= 1'b0;
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    if (i_sts.at_goal) begin
                        r_found <= 1'b1;
                        r_state <= S_RES;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_BA;
                    end
                end
                S_BA: r_state <= S_BR;
                S_BR: r_state <= S_BS;
                S_BS: begin
                    r_k     <= r_k + 3'd1;
                    r_state <= (r_k == 3'd7) ? S_EA : S_BA;
                end
                S_EA: begin
                    if (i_sts.pass) begin
                        r_state <= S_ER;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= (r_k == 3'd7) ? S_POP : S_EA;
                    end
                end
                S_ER: r_state <= S_EC;
                S_EC: begin
                    r_k     <= r_k + 3'd1;
                    r_state <= (r_k == 3'd7) ? S_POP : S_EA;
                end
                S_RES: if (!i_sts.out_full) r_state <= S_LOAD;
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

// File: verif/tb_grid_bfs_shortest_path_unit.sv
`timescale 1ns / 1ps
// Testbench for the grid shortest-path search unit, checked against its own search model.
module tb_grid_bfs_shortest_path_unit;
    import gbsp_pkg::*;

    localparam int NCOLS   = 64;
    localparam int NROWS   = 64;
    localparam int NCELLS  = NCOLS * NROWS;
    localparam int N_ITEMS = 1050;

    typedef struct packed {
        logic        found;
        logic [11:0] steps;
    } t_path_res;

    typedef struct {
        logic      blocked;
        logic      last;
        logic      has_fixed;
        t_path_res fixed;
    } t_cell_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gbsp_cell_if cell_ch ();
    gbsp_res_if  res_ch ();
    gbsp_cfg_if  cfg_ch ();

    grid_bfs_shortest_path_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cell (cell_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    logic [6:0]  m_cols = 7'd64;
    logic [6:0]  m_rows = 7'd64;
    logic [5:0]  m_scol = '0;
    logic [5:0]  m_srow = '0;
    logic [5:0]  m_gcol = '0;
    logic [5:0]  m_grow = '0;
    logic        m_blk [NCELLS];
    logic [12:0] m_load_idx = '0;

    t_path_res path_q[$];
    logic      fixed_q[$];
    t_path_res fixed_val_q[$];
    int        err_cnt = 0;
    int        res_cnt = 0;
    int        found_cnt = 0;
    int        sent_cnt = 0;
    int        sink_wait = 0;
    bit        hold_sink = 1'b0;

    function automatic bit cell_open(int c, int r, int cols, int rows);
        if (c < 0 || r < 0 || c >= cols || r >= rows) return 1'b0;
        return m_blk[r * cols + c] == 1'b0;
    endfunction

    function automatic t_path_res shortest_path();
        int        cols;
        int        rows;
        int        src;
        int        dst;
        int        head;
        int        tail;
        int        cur;
        int        c;
        int        r;
        int        nc;
        int        nr;
        int        nxt;
        int        dx [8];
        int        dy [8];
        bit        seen [NCELLS];
        int        hops [NCELLS];
        int        fifo [NCELLS];
        t_path_res res;
        dx = '{0, 1, 1, 1, 0, -1, -1, -1};
        dy = '{1, 1, 0, -1, -1, -1, 0, 1};
        res = '0;
        cols = (m_cols > 64) ? 64 : m_cols;
        rows = (m_rows > 64) ? 64 : m_rows;
        if (cols == 0 || rows == 0) return res;
        if (m_scol >= cols || m_srow >= rows || m_gcol >= cols || m_grow >= rows)
            return res;
        src = m_srow * cols + m_scol;
        dst = m_grow * cols + m_gcol;
        foreach (seen[i]) seen[i] = 1'b0;
        head = 0;
        tail = 0;
        seen[src] = 1'b1;
        hops[src] = 0;
        fifo[tail++] = src;
        while (head < tail) begin
            cur = fifo[head++];
            if (cur == dst) begin
                res.found = 1'b1;
                res.steps = (hops[cur] > 4095) ? 12'd4095 : hops[cur][11:0];
                return res;
            end
            c = cur % cols;
            r = cur / cols;
            for (int k = 0; k < 8; k++) begin
                nc = c + dx[k];
                nr = r + dy[k];
                if (!cell_open(nc, nr, cols, rows)) continue;
                if (dx[k] != 0 && dy[k] != 0 &&
                    (!cell_open(c + dx[k], r, cols, rows) ||
                     !cell_open(c, r + dy[k], cols, rows))) continue;
                nxt = nr * cols + nc;
                if (seen[nxt]) continue;
                seen[nxt] = 1'b1;
                hops[nxt] = hops[cur] + 1;
                if (tail < NCELLS) fifo[tail++] = nxt;
            end
        end
        return res;
    endfunction

    function automatic void take_cell(logic blocked, logic last, logic has_fixed,
                                      t_path_res fixed);
        if (m_load_idx < NCELLS) begin
            m_blk[m_load_idx] = blocked;
            m_load_idx++;
        end
        if (last) begin
            m_load_idx = '0;
            path_q.insert(path_q.size(), shortest_path());
            fixed_q.insert(fixed_q.size(), has_fixed);
            fixed_val_q.insert(fixed_val_q.size(), fixed);
        end
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [6:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_GRID_COLS: m_cols = val;
            REG_GRID_ROWS: m_rows = val;
            REG_START_COL: m_scol = val[5:0];
            REG_START_ROW: m_srow = val[5:0];
            REG_GOAL_COL:  m_gcol = val[5:0];
            default:       m_grow = val[5:0];
        endcase
    endtask

    task automatic set_search(int cols, int rows, int sc, int sr, int gc, int gr);
        write_reg(REG_GRID_COLS, cols[6:0]);
        write_reg(REG_GRID_ROWS, rows[6:0]);
        write_reg(REG_START_COL, sc[6:0]);
        write_reg(REG_START_ROW, sr[6:0]);
        write_reg(REG_GOAL_COL, gc[6:0]);
        write_reg(REG_GOAL_ROW, gr[6:0]);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_cell(logic blocked, logic last, logic has_fixed, t_path_res fixed);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_ch.valid        <= 1'b1;
        cell_ch.cell_blocked <= blocked;
        cell_ch.last_cell    <= last;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        sent_cnt++;
        take_cell(blocked, last, has_fixed, fixed);
    endtask

    task automatic drain_idle();
        cell_ch.valid <= 1'b0;
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (NCELLS + 50) @(posedge i_clk);
    endtask

    task automatic send_map(int ncells, int pct_blk);
        for (int i = 0; i < ncells; i++)
            send_cell(($urandom_range(0, 99) < pct_blk), (i == ncells - 1), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_path_res want;
        logic      has_fixed;
        t_path_res fixed;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            res_cnt++;
            if (res_ch.found) found_cnt++;
            if (path_q.size() == 0) begin
                $error("result with nothing expected: found=%0d steps=%0d",
                       res_ch.found, res_ch.steps);
                err_cnt++;
            end else begin
                want = path_q[0];
                path_q.delete(0);
                has_fixed = fixed_q[0];
                fixed_q.delete(0);
                fixed = fixed_val_q[0];
                fixed_val_q.delete(0);
                if (has_fixed) want = fixed;
                if (res_ch.found !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, res_ch.found);
                    err_cnt++;
                end
                if (res_ch.steps !== want.steps) begin
                    $error("steps: expected %0d actual %0d", want.steps, res_ch.steps);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_wait = $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end else if (hold_sink) begin
            res_ch.ready <= 1'b0;
        end else if (res_ch.valid && res_ch.ready) begin
            sink_wait = $urandom_range(0, 6);
            res_ch.ready <= (sink_wait == 0);
        end else if (sink_wait != 0) begin
            sink_wait--;
            res_ch.ready <= (sink_wait == 0);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    initial begin
        #400ms;
        $display("tb_grid_bfs_shortest_path_unit NOT OK");
        $finish;
    end

    initial begin
        t_cell_row dir_rows [$];
        t_path_res hit0;
        t_path_res miss;
        int        w;
        int        h;
        int        n;
        cell_ch.valid        = 1'b0;
        cell_ch.cell_blocked = 1'b0;
        cell_ch.last_cell    = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.addr          = '0;
        cfg_ch.data          = '0;
        foreach (m_blk[i]) m_blk[i] = 1'b0;
        hit0 = '{found: 1'b1, steps: 12'd0};
        miss = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: start equals goal on the full grid, even when blocked
        dir_rows.insert(dir_rows.size(), t_cell_row'{1'b1, 1'b1, 1'b1, hit0});
        foreach (dir_rows[i])
            send_cell(dir_rows[i].blocked, dir_rows[i].last, dir_rows[i].has_fixed,
                      dir_rows[i].fixed);
        drain_idle();

        // 3x3 corner tests with row table
        set_search(3, 3, 0, 0, 2, 2);
        dir_rows.delete();
        for (int i = 0; i < 9; i++)
            dir_rows.insert(dir_rows.size(), t_cell_row'{1'b0, i == 8, 1'b0, miss});
        for (int i = 0; i < 9; i++)
            dir_rows.insert(dir_rows.size(),
                            t_cell_row'{(i == 1 || i == 3), i == 8, 1'b0, miss});
        for (int i = 0; i < 9; i++)
            dir_rows.insert(dir_rows.size(), t_cell_row'{i == 4, i == 8, 1'b0, miss});
        foreach (dir_rows[i])
            send_cell(dir_rows[i].blocked, dir_rows[i].last, dir_rows[i].has_fixed,
                      dir_rows[i].fixed);
        drain_idle();

        // goal outside the grid, zero sizes, oversize saturation
        set_search(1, 1, 0, 0, 1, 0);
        send_cell(1'b0, 1'b1, 1'b1, miss);
        drain_idle();
        set_search(0, 5, 0, 0, 0, 0);
        send_cell(1'b0, 1'b1, 1'b1, miss);
        drain_idle();
        set_search(127, 127, 63, 63, 63, 63);
        send_cell(1'b1, 1'b1, 1'b1, hit0);
        drain_idle();

        // full 64x64 grid corner to corner, one cell streamed, rest kept
        set_search(64, 64, 0, 0, 63, 63);
        send_cell(1'b0, 1'b1, 1'b0, '0);
        drain_idle();

        // long snake path on a narrow grid
        set_search(3, 40, 0, 0, 0, 39);
        for (int r = 0; r < 40; r++)
            for (int c = 0; c < 3; c++)
                send_cell((r % 2 == 1) && (c != ((r % 4 == 1) ? 2 : 0)),
                          (r == 39 && c == 2), 1'b0, '0);
        drain_idle();

        // receiver holds off while maps keep coming
        set_search(2, 2, 0, 0, 1, 1);
        fork
            begin
                hold_sink = 1'b1;
                repeat (20000) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_map(1, 0);
        join
        drain_idle();

        // random: mostly small grids, short or overlong maps now and then
        while (sent_cnt < N_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
            if (w * h > 100) begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 10);
            end
            set_search(w, h, $urandom_range(0, w), $urandom_range(0, h),
                       $urandom_range(0, w), $urandom_range(0, h));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * w * h + 1)
                                            : ((w * h == 0) ? 1 : w * h);
            if (n > N_ITEMS - sent_cnt) n = N_ITEMS - sent_cnt;
            send_map(n, $urandom_range(0, 40));
            drain_idle();
        end

        repeat (50) @(posedge i_clk);
        $display("ran %0d searches over %0d cells, %0d reached the goal",
                 res_cnt, sent_cnt, found_cnt);
        $display("included corner, bound, snake and output stall cases");
        if (err_cnt == 0 && path_q.size() == 0) begin
            $display("tb_grid_bfs_shortest_path_unit OK");
        end else begin
            $display("tb_grid_bfs_shortest_path_unit NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/gbsp_pkg.sv
hdl/gbsp_if.sv
hdl/gbsp_dp.sv
hdl/gbsp_ctrl.sv
hdl/grid_bfs_shortest_path_unit.sv
verif/tb_grid_bfs_shortest_path_unit.sv
